@@ rtl/core/stxr_pkg.sv @@
// ----------------------------------------------------------------------------
// stxr_pkg: shared types and constants of the STX/ETX frame receiver
// Frame positions, status codes, register indexes and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package stxr_pkg;

   // Frame layout
   localparam int unsigned POS_WIDTH = 4;
   localparam logic [POS_WIDTH-1:0] POS_HUNT          = 4'd0;
   localparam logic [POS_WIDTH-1:0] POS_LENGTH        = 4'd1;
   localparam logic [POS_WIDTH-1:0] POS_ID            = 4'd2;
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD_FIRST = 4'd3;
   localparam logic [POS_WIDTH-1:0] POS_PAYLOAD_LAST  = 4'd10;
   localparam logic [POS_WIDTH-1:0] POS_CHECKSUM      = 4'd11;
   localparam logic [POS_WIDTH-1:0] POS_END           = 4'd12;

   localparam int unsigned PAYLOAD_BYTES = 8;

   // Frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_END   = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHECK = 2'd2;

   // Register indexes and reset values
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_BYTE   = 4'd1;
   localparam logic [7:0] START_BYTE_RESET = 8'h02;
   localparam logic [7:0] END_BYTE_RESET   = 8'h03;

   // One result item
   typedef struct packed {
      logic [63:0] payload;
      logic [7:0]  frame_id;
      logic [7:0]  frame_length;
      logic [1:0]  frame_status;
   } frame_result_type;

   localparam int unsigned RSP_DATA_WIDTH = 88;

endpackage

`default_nettype wire

@@ rtl/core/stxr_collect.sv @@
// ----------------------------------------------------------------------------
// stxr_collect: frame hunter and collector
// Tracks the byte position, holds length, ID, payload and checksum bytes,
// keeps the running sum and builds the result item at the end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stxr_collect
   import stxr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [7:0]       in_byte,
   output logic                  in_ready,
   input  wire logic             out_free,
   input  wire logic [7:0]       start_byte,
   input  wire logic [7:0]       end_byte,
   output logic                  result_valid,
   output frame_result_type      result
);

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           length_ff, length_in;
   logic [7:0]           id_ff, id_in;
   logic [63:0]          payload_ff, payload_in;
   logic [7:0]           check_ff, check_in;
   logic                 hunting;
   logic                 at_end;
   logic                 accept;

   assign hunting  = (pos_ff == POS_HUNT) || (pos_ff > POS_END);
   assign at_end   = (pos_ff == POS_END);
   // Stall only on the end byte, and only while the result slot is taken
   assign in_ready = !at_end || out_free;
   assign accept   = in_valid && in_ready;

   // Next position and collected fields
   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      length_in  = length_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      check_in   = check_ff;
      if (accept) begin
         if (hunting) begin
            if (in_byte == start_byte) begin
               pos_in     = POS_LENGTH;
               sum_in     = '0;
               length_in  = '0;
               id_in      = '0;
               payload_in = '0;
               check_in   = '0;
            end else begin
               pos_in = POS_HUNT;
            end
         end else if (at_end) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff >= POS_ID && pos_ff <= POS_PAYLOAD_LAST) begin
               sum_in = sum_ff + in_byte;
            end
            if (pos_ff == POS_LENGTH) begin
               length_in = in_byte;
            end
            if (pos_ff == POS_ID) begin
               id_in = in_byte;
            end
            if (pos_ff == POS_CHECKSUM) begin
               check_in = in_byte;
            end
            // Write the byte lane that matches the position
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               if (pos_ff == POS_PAYLOAD_FIRST + POS_WIDTH'(i)) begin
                  payload_in[8*i +: 8] = in_byte;
               end
            end
         end
      end
   end

   // Build the result on the end byte; end byte checked before checksum
   always_comb begin
      result_valid        = accept && at_end;
      result.frame_length = length_ff;
      result.frame_id     = id_ff;
      result.payload      = payload_ff;
      priority if (in_byte != end_byte) begin
         result.frame_status = STATUS_BAD_END;
      end else if (check_ff != sum_ff) begin
         result.frame_status = STATUS_BAD_CHECK;
      end else begin
         result.frame_status = STATUS_OK;
      end
   end

   // Position register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // Collected fields
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         length_ff  <= '0;
         id_ff      <= '0;
         payload_ff <= '0;
         check_ff   <= '0;
      end else begin
         sum_ff     <= sum_in;
         length_ff  <= length_in;
         id_ff      <= id_in;
         payload_ff <= payload_in;
         check_ff   <= check_in;
      end
   end

   // Position never leaves the frame range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_END)
      else $error("byte position out of range");

   // A result is produced only into a free slot
   a_result_free: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> out_free)
      else $error("result produced while slot is taken");

   // After the end byte the block hunts again
   a_end_hunt: assert property (@(posedge clock) disable iff (reset)
      (accept && at_end) |=> (pos_ff == POS_HUNT))
      else $error("no return to hunting after end byte");

endmodule

`default_nettype wire

@@ rtl/core/stxr_out_reg.sv @@
// ----------------------------------------------------------------------------
// stxr_out_reg: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module stxr_out_reg
   import stxr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  frame_result_type      result,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int unsigned PAD_WIDTH = RSP_DATA_WIDTH - $bits(frame_result_type);

   logic             valid_ff, valid_in;
   frame_result_type data_ff;

   assign free = !valid_ff || rsp_tready;

   // Set on load, clear when taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_WIDTH{1'b0}}, data_ff};

endmodule

`default_nettype wire

@@ rtl/core/stx_etx_frame_receiver.sv @@
// The result item appears in the cycle after the end byte is accepted.
// Throughput: one received byte per cycle but for the end byte stall below; one result per 13-byte frame.
// The end byte is held off only while the previous result still waits.
// Reset (synchronous, active high) returns to hunting, clears the collected
// fields and loads start byte 0x02 and end byte 0x03; no clearing pass.
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver: STX/ETX frame receiver with additive checksum
// Hunts for the start byte, collects a 13-byte frame and reports its status,
// length, ID and payload.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_frame_receiver
   import stxr_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Received byte stream
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,  // [7:0] rx_byte
   // Frame results
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [1:0] frame_status, [9:2] frame_length, [17:10] frame_id,
   // [81:18] payload, [87:82] zero
   output logic [RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // Register writes
   input  wire logic                       csr_wen,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_wdata
);

   logic [7:0]       start_byte_ff;
   logic [7:0]       end_byte_ff;
   logic             out_free;
   logic             result_valid;
   frame_result_type result;

   // Configuration registers; other indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
      end else if (csr_wen) begin
         if (csr_index == CSR_START_BYTE) begin
            start_byte_ff <= csr_wdata;
         end
         if (csr_index == CSR_END_BYTE) begin
            end_byte_ff <= csr_wdata;
         end
      end
   end

   stxr_collect u_collect (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_byte      (req_tdata),
      .in_ready     (req_tready),
      .out_free     (out_free),
      .start_byte   (start_byte_ff),
      .end_byte     (end_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   stxr_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_valid),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ tb/sv/stx_etx_frame_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_tb: self-checking bench for the STX/ETX frame receiver
// Streams received bytes into the block. Most of them are well-formed frames
// with random content, and the rest are noise, truncated frames and frames
// with a bad checksum or a bad end byte. The bench runs under several start
// and end byte settings and with random stalls on both channels. A frame
// predictor follows every accepted byte, and each result item is compared
// field by field with the oldest predicted frame.
// ----------------------------------------------------------------------------
`default_nettype none

module stx_etx_frame_receiver_tb;
   import stxr_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned SETTLE_CYCLES  = 3;
   localparam int unsigned MISMATCH_SHOWN = 10;
   localparam int unsigned RESULT_BITS    = $bits(frame_result_type);

   // Kinds of frame that the random stimulus builds
   typedef enum int unsigned {
      FRAME_GOOD,
      FRAME_BAD_END,
      FRAME_BAD_SUM,
      FRAME_BAD_BOTH,
      FRAME_CUT
   } frame_kind_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata = 8'h00;   // [7:0] rx_byte
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // [1:0] frame_status, [9:2] frame_length, [17:10] frame_id,
   // [81:18] payload, [87:82] zero
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [7:0]                 csr_wdata = 8'h00;

   // Stall control shared by both channels
   bit idle_enable = 1'b1;

   // Marker values that the stimulus frames are built with
   logic [7:0] start_mark = START_BYTE_RESET;
   logic [7:0] end_mark   = END_BYTE_RESET;

   // Frame predictor state
   logic [7:0]          cfg_start;
   logic [7:0]          cfg_end;
   logic [POS_WIDTH-1:0] frm_pos;
   logic [7:0]          frm_sum;
   logic [7:0]          frm_length;
   logic [7:0]          frm_id;
   logic [63:0]         frm_payload;
   logic [7:0]          frm_rx_sum;

   frame_result_type frames_pending[$];
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;

   stx_etx_frame_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predict the frame result, if any, that one accepted byte completes
   function automatic void absorb_rx_byte(input logic [7:0] b);
      frame_result_type res;
      if (frm_pos == POS_HUNT || frm_pos > POS_END) begin
         if (b == cfg_start) begin
            frm_pos     = POS_LENGTH;
            frm_sum     = 8'h00;
            frm_length  = 8'h00;
            frm_id      = 8'h00;
            frm_payload = 64'h0;
            frm_rx_sum  = 8'h00;
         end else begin
            frm_pos = POS_HUNT;
         end
         return;
      end
      if (frm_pos >= POS_ID && frm_pos <= POS_PAYLOAD_LAST) begin
         frm_sum = frm_sum + b;
      end
      if (frm_pos == POS_LENGTH) begin
         frm_length = b;
      end else if (frm_pos == POS_ID) begin
         frm_id = b;
      end else if (frm_pos <= POS_PAYLOAD_LAST) begin
         frm_payload[8 * (frm_pos - POS_PAYLOAD_FIRST) +: 8] = b;
      end else if (frm_pos == POS_CHECKSUM) begin
         frm_rx_sum = b;
      end else begin
         // End byte is checked ahead of the checksum
         if (b != cfg_end) begin
            res.frame_status = STATUS_BAD_END;
         end else if (frm_rx_sum != frm_sum) begin
            res.frame_status = STATUS_BAD_CHECK;
         end else begin
            res.frame_status = STATUS_OK;
         end
         res.frame_length = frm_length;
         res.frame_id     = frm_id;
         res.payload      = frm_payload;
         frames_pending.push_back(res);
         frm_pos = POS_HUNT;
         return;
      end
      frm_pos = frm_pos + 1'b1;
   endfunction

   function automatic void note_mismatch(input string field, input logic [63:0] want,
                                         input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN) begin
         $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
   endfunction

   // Follow both channels and the register port; check each result item
   always @(posedge clock) begin
      frame_result_type want;
      frame_result_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stx_etx_frame_receiver verification failed");
         $finish;
      end
      if (reset) begin
         cfg_start   = START_BYTE_RESET;
         cfg_end     = END_BYTE_RESET;
         frm_pos     = POS_HUNT;
         frm_sum     = 8'h00;
         frm_length  = 8'h00;
         frm_id      = 8'h00;
         frm_payload = 64'h0;
         frm_rx_sum  = 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_rx_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RESULT_BITS-1:0];
            if (frames_pending.size() == 0) begin
               note_mismatch("unexpected result", 64'h0, got.payload);
            end else begin
               want = frames_pending.pop_front();
               if (got.frame_status != want.frame_status)
                  note_mismatch("frame_status", 64'(want.frame_status),
                                64'(got.frame_status));
               if (got.frame_length != want.frame_length)
                  note_mismatch("frame_length", 64'(want.frame_length),
                                64'(got.frame_length));
               if (got.frame_id != want.frame_id)
                  note_mismatch("frame_id", 64'(want.frame_id), 64'(got.frame_id));
               if (got.payload != want.payload)
                  note_mismatch("payload", want.payload, got.payload);
            end
            if (rsp_tdata[RSP_DATA_WIDTH-1:RESULT_BITS] != '0)
               note_mismatch("padding", 64'h0,
                             64'(rsp_tdata[RSP_DATA_WIDTH-1:RESULT_BITS]));
         end
         // New marker values apply from the next byte on
         if (csr_wen) begin
            if (csr_index == CSR_START_BYTE) begin
               cfg_start = csr_wdata;
            end else if (csr_index == CSR_END_BYTE) begin
               cfg_end = csr_wdata;
            end
         end
      end
   end

   // Result side: stall in random bursts while idling is enabled
   initial begin
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Send one byte and hold it until the block takes it
   task automatic send_rx_byte(input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted frame has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      // Let the predictor take in the last accepted byte first
      @(posedge clock);
      while (frames_pending.size() != 0 || rsp_tvalid) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                              input logic [7:0] value);
      drain_results();
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (index == CSR_START_BYTE) begin
         start_mark = value;
      end else if (index == CSR_END_BYTE) begin
         end_mark = value;
      end
   endtask

   // Build a frame around the current markers; send only its first cut bytes
   task automatic send_frame(input logic [7:0] length, input logic [7:0] id,
                             input logic [63:0] payload, input bit sum_ok,
                             input bit end_ok, input int cut);
      logic [7:0] frame_bytes [0:12];
      logic [7:0] sum;
      int i;
      sum = id;
      for (i = 0; i < PAYLOAD_BYTES; i++) begin
         sum = sum + payload[8 * i +: 8];
         frame_bytes[POS_PAYLOAD_FIRST + i] = payload[8 * i +: 8];
      end
      frame_bytes[POS_HUNT]     = start_mark;
      frame_bytes[POS_LENGTH]   = length;
      frame_bytes[POS_ID]       = id;
      frame_bytes[POS_CHECKSUM] = sum_ok ? sum : sum ^ 8'($urandom_range(1, 255));
      frame_bytes[POS_END]      = end_ok ? end_mark : end_mark ^ 8'($urandom_range(1, 255));
      for (i = 0; i < cut; i++) begin
         send_rx_byte(frame_bytes[i]);
      end
   endtask

   // Good, checksum-only and doubly broken frames, with field extremes
   task automatic test_frame_kinds();
      send_rx_byte(8'hFF);
      send_rx_byte(8'h00);
      // Start byte value inside the payload is plain data
      send_frame(8'h00, 8'hFF, {8'hFF, 8'h00, start_mark, start_mark, 8'h80, 8'h7F,
                 8'h00, 8'hFF}, 1'b1, 1'b1, 13);
      send_frame(8'hFF, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 13);
      send_frame(8'hA5, 8'h5A, 64'h0, 1'b0, 1'b0, 13);
   endtask

   // Change the end marker while a frame is half collected
   task automatic test_marker_change_mid_frame();
      logic [63:0] payload;
      logic [7:0]  sum;
      int i;
      payload = 64'h1716_1514_1312_1110;
      sum = 8'h3C;
      send_rx_byte(start_mark);
      send_rx_byte(8'h0D);
      send_rx_byte(8'h3C);
      for (i = 0; i < 3; i++) begin
         send_rx_byte(payload[8 * i +: 8]);
         sum = sum + payload[8 * i +: 8];
      end
      program_reg(CSR_END_BYTE, 8'hE7);
      for (i = 3; i < PAYLOAD_BYTES; i++) begin
         send_rx_byte(payload[8 * i +: 8]);
         sum = sum + payload[8 * i +: 8];
      end
      send_rx_byte(sum);
      send_rx_byte(end_mark);
   endtask

   // Writes to unused register indexes leave the markers alone
   task automatic test_unused_register_index();
      program_reg(CSR_INDEX_WIDTH'($urandom_range(CSR_END_BYTE + 1, 2**CSR_INDEX_WIDTH - 1)),
                  8'($urandom_range(0, 255)));
      send_frame(8'h42, 8'h24, {$urandom, $urandom}, 1'b1, 1'b1, 13);
   endtask

   // Mostly well-formed frames with random content, some noise and breakage
   task automatic test_random_frames(input logic [7:0] start_value,
                                     input logic [7:0] end_value,
                                     input int frames, input bit with_idle);
      frame_kind_type kind;
      logic [7:0]     noise;
      int f;
      int n;
      int pick;
      program_reg(CSR_START_BYTE, start_value);
      program_reg(CSR_END_BYTE, end_value);
      program_reg(CSR_INDEX_WIDTH'($urandom_range(CSR_END_BYTE + 1, 2**CSR_INDEX_WIDTH - 1)),
                  8'($urandom_range(0, 255)));
      idle_enable = with_idle;
      for (f = 0; f < frames; f++) begin
         // Hold the sender once until every result is out
         if (f == frames / 2) begin
            drain_results();
         end
         // Noise that holds no start byte value
         for (n = $urandom_range(0, 2); n > 0; n--) begin
            noise = 8'($urandom_range(0, 255));
            send_rx_byte(noise == start_mark ? ~noise : noise);
         end
         // Raw noise that may open a frame by chance
         if ($urandom_range(0, 9) == 0) begin
            for (n = $urandom_range(1, 4); n > 0; n--) begin
               send_rx_byte(8'($urandom_range(0, 255)));
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) kind = FRAME_GOOD;
         else if (pick < 75) kind = FRAME_BAD_END;
         else if (pick < 90) kind = FRAME_BAD_SUM;
         else if (pick < 95) kind = FRAME_BAD_BOTH;
         else kind = FRAME_CUT;
         send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    {$urandom, $urandom},
                    kind == FRAME_GOOD || kind == FRAME_BAD_END || kind == FRAME_CUT,
                    kind == FRAME_GOOD || kind == FRAME_BAD_SUM || kind == FRAME_CUT,
                    kind == FRAME_CUT ? $urandom_range(1, 12) : 13);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_frame_kinds();
      test_marker_change_mid_frame();
      test_unused_register_index();
      test_random_frames(8'h00, 8'hFF, 18, 1'b1);
      test_random_frames(8'hFF, 8'h00, 18, 1'b1);
      test_random_frames(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 18, 1'b1);
      test_random_frames(START_BYTE_RESET, END_BYTE_RESET, 18, 1'b0);

      // Let the last result through, then give the block time to misbehave
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && frames_pending.size() == 0) begin
         $display("stx_etx_frame_receiver verification clean");
      end else begin
         $display("stx_etx_frame_receiver verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/stxr_pkg.sv
rtl/core/stxr_collect.sv
rtl/core/stxr_out_reg.sv
rtl/core/stx_etx_frame_receiver.sv
tb/sv/stx_etx_frame_receiver_tb.sv
